// File: hdl/deq_pkg.sv
// ============================================================================
// deq_pkg
// Shared types, widths and helpers for the double-ended queue.
// ============================================================================
package deq_pkg;

    // Ring store size and derived widths
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the request and response
    localparam int OP_W  = 3;
    localparam int VAL_W = 16;
    localparam int POS_W = 7;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5,
        OP_INSERT     = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Result handed from the controller to the output register
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic                    is_empty;
        logic [POS_W-1:0]        occupancy;
    } deq_result_t;

    // Physical slot of a logical offset from the head (head + off < 2*DEPTH)
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Head index one place toward the front, with wrap
    function automatic logic [IDX_W-1:0] head_dec(input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] res;
        if (head == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = head - 1'b1;
        end
        return res;
    endfunction

endpackage

// File: hdl/deq_if.sv
// ============================================================================
// deq_if
// Valid/ready channels for requests and responses of the queue.
// ============================================================================
interface deq_req_if import deq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic                    is_empty;
    logic [POS_W-1:0]        occupancy;

    modport source (output valid, output read_value, output status, output is_empty,
                    output occupancy, input ready);
    modport sink   (input valid, input read_value, input status, input is_empty,
                    input occupancy, output ready);
endinterface

// File: hdl/double_ended_queue.sv
// ============================================================================
// double_ended_queue
// Bounded deque of signed 16-bit values in a ring store, with output register.
// ============================================================================
//   channel   dir   payload
//   req       in    operation, value, position
//   rsp       out   read_value, status, is_empty, occupancy
//
// Push, clear and every rejected request produce their result in the cycle
// they are accepted; pop and read return data via the registered read port.
// Insert past the front moves one entry per cycle through the single write
// port, back to front in S_SHIFT, then drains and writes in S_INS_WR.
// Reset clears head and count; store contents stay undefined. A held response
// stalls request acceptance and the last result; a running shift keeps going.
module double_ended_queue import deq_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    deq_req_if.sink req,
    deq_rsp_if.source rsp
);

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [VAL_W-1:0]        wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [VAL_W-1:0]        rd_data;
    deq_result_t             result;
    logic                    out_free;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [ST_W-1:0]         out_status_reg;
    logic                    out_empty_reg;
    logic [POS_W-1:0]        out_occ_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    deq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .result   (result)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_value_reg  <= result.read_value;
            out_status_reg <= result.status;
            out_empty_reg  <= result.is_empty;
            out_occ_reg    <= result.occupancy;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.is_empty   = out_empty_reg;
    assign rsp.occupancy  = out_occ_reg;

endmodule

// File: hdl/deq_ram.sv
// ============================================================================
// deq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module deq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/deq_ctrl.sv
// ============================================================================
// deq_ctrl
// Request decode, head/count bookkeeping and the insert shift sequencer.
// ============================================================================
module deq_ctrl import deq_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    deq_req_if.sink             req,
    input  logic                out_free,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output logic [VAL_W-1:0]    wr_data,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [VAL_W-1:0]    rd_data,
    output deq_result_t         result
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RDATA  = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_INS_WR = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rd_off_reg, rd_off_next;
    logic [CNT_W-1:0]        wr_off_reg, wr_off_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [VAL_W-1:0]        val_reg, val_next;

    op_t                     op;
    logic                    full;
    logic                    empty;
    logic [CNT_W-1:0]        pos_c;
    logic [CNT_W-1:0]        ins_limit;
    logic [CNT_W-1:0]        pos_m1;
    status_t                 st;
    logic                    res_valid;
    logic signed [VAL_W-1:0] res_value;

    assign op        = op_t'(req.operation);
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_c     = CNT_W'(req.position);
    assign ins_limit = empty ? CNT_W'(1) : count_reg;
    assign pos_m1    = CNT_W'(pos_reg) - 1'b1;

    // Next-state and memory access decode
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rd_off_next = rd_off_reg;
        wr_off_next = wr_off_reg;
        rd_vld_next = rd_vld_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = req.value;
        rd_en       = 1'b0;
        rd_addr     = '0;
        req.ready   = 1'b0;
        res_valid   = 1'b0;
        res_value   = '0;
        st          = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = out_free;
                if (req.valid && out_free)
                begin
                    unique case (op)
                        OP_PUSH_BACK:
                        begin
                            res_valid = 1'b1;
                            if (full)
                            begin
                                st = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = slot_of(head_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            res_valid = 1'b1;
                            if (full)
                            begin
                                st = ST_FULL;
                            end
                            else
                            begin
                                head_next  = head_dec(head_reg);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_valid = 1'b1;
                                st        = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                head_next  = slot_of(head_reg, CNT_W'(1));
                                count_next = count_reg - 1'b1;
                                state_next = S_RDATA;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_valid = 1'b1;
                                st        = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_of(head_reg, count_reg - 1'b1);
                                count_next = count_reg - 1'b1;
                                state_next = S_RDATA;
                            end
                        end
                        OP_READ_FRONT, OP_READ_BACK:
                        begin
                            if (empty)
                            begin
                                res_valid = 1'b1;
                                st        = ST_EMPTY;
                            end
                            else if (req.position == '0 || pos_c > count_reg)
                            begin
                                res_valid = 1'b1;
                                st        = ST_BADPOS;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = (op == OP_READ_FRONT)
                                           ? slot_of(head_reg, pos_c - 1'b1)
                                           : slot_of(head_reg, count_reg - pos_c);
                                state_next = S_RDATA;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                res_valid = 1'b1;
                                st        = ST_FULL;
                            end
                            else if (req.position == '0 || pos_c > ins_limit)
                            begin
                                res_valid = 1'b1;
                                st        = ST_BADPOS;
                            end
                            else if (pos_c == CNT_W'(1))
                            begin
                                // front insert is a push front
                                res_valid  = 1'b1;
                                head_next  = head_dec(head_reg);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                pos_next    = req.position;
                                val_next    = req.value;
                                rd_off_next = count_reg - 1'b1;
                                rd_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            res_valid  = 1'b1;
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end

            // Pop or read data returns from the store
            S_RDATA:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    res_value  = rd_data;
                    state_next = S_IDLE;
                end
            end

            // Move entries one place back, read and write overlapped
            S_SHIFT:
            begin
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_of(head_reg, wr_off_reg);
                    wr_data = rd_data;
                end
                if (rd_off_reg >= pos_m1)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = slot_of(head_reg, rd_off_reg);
                    rd_vld_next = 1'b1;
                    wr_off_next = rd_off_reg + 1'b1;
                    rd_off_next = rd_off_reg - 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                    state_next  = S_INS_WR;
                end
            end

            // Drop the new value into the gap
            S_INS_WR:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = slot_of(head_reg, pos_m1);
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result toward the output register
    always_comb
    begin
        result.valid      = res_valid;
        result.read_value = res_value;
        result.status     = st;
        result.is_empty   = (count_next == '0);
        result.occupancy  = POS_W'(count_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Insert working registers
    always_ff @(posedge clk)
    begin
        rd_off_reg <= rd_off_next;
        wr_off_reg <= wr_off_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
    end

endmodule
